@@ src/dbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dbs_pkg: shared types and constants of the dead band scaler
// Configuration register indexes, mode codes, the configuration bundle and
// the payload records that travel down the divider pipeline.
// ---------------------------------------------------------------------------
package dbs_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_INPUT_MODE      = 3'd0;
	localparam logic [2:0] REG_DEAD_BAND_WIDTH = 3'd1;
	localparam logic [2:0] REG_IN_LOW          = 3'd2;
	localparam logic [2:0] REG_IN_MIDDLE       = 3'd3;
	localparam logic [2:0] REG_IN_HIGH         = 3'd4;
	localparam logic [2:0] REG_OUT_LOW         = 3'd5;
	localparam logic [2:0] REG_OUT_HIGH        = 3'd6;

	// Divider layout: a 32-bit magnitude quotient, four bits per stage.
	localparam int DIV_BITS       = 32;
	localparam int DIV_PER_STAGE  = 4;
	localparam int DIV_STAGES     = DIV_BITS / DIV_PER_STAGE;
	localparam int DVS_BITS       = 17;

	// Input modes; the last code behaves like the first.
	typedef enum logic [1:0] {
		MODE_IGNORED  = 2'd0,
		MODE_NORMAL   = 2'd1,
		MODE_MID_REST = 2'd2,
		MODE_IGNORED2 = 2'd3
	} mode_t;

	// Configuration registers as seen by the datapath.
	typedef struct packed {
		mode_t              mode;
		logic [14:0]        dead_band_width;
		logic signed [15:0] in_low;
		logic signed [15:0] in_middle;
		logic signed [15:0] in_high;
		logic signed [15:0] out_low;
		logic [14:0]        out_high;
	} cfg_t;

	// Long division working set: partial remainder, dividend bits that
	// shift out at the top while quotient bits shift in at the bottom,
	// and the divisor magnitude.
	typedef struct packed {
		logic [DVS_BITS-1:0] rem;
		logic [DIV_BITS-1:0] dd;
		logic [DVS_BITS-1:0] dvs;
	} div_t;

	// Side information that rides along with each transaction.
	typedef struct packed {
		logic               neg;
		logic               zero;
		logic               fault;
		logic               band;
		logic signed [15:0] lo;
		logic signed [15:0] hi;
	} side_t;

	// One restoring division step.
	function automatic div_t div_step(div_t d);
		logic [DVS_BITS:0] shifted;
		logic [DVS_BITS:0] diff;
		div_t              r;
		shifted = {d.rem, d.dd[DIV_BITS-1]};
		diff    = shifted - {1'b0, d.dvs};
		r       = d;
		if (shifted >= {1'b0, d.dvs}) begin
			r.rem = diff[DVS_BITS-1:0];
			r.dd  = {d.dd[DIV_BITS-2:0], 1'b1};
		end else begin
			r.rem = shifted[DVS_BITS-1:0];
			r.dd  = {d.dd[DIV_BITS-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ src/dbs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dbs_front: branch selection, multiply and sign split
// Stage 1 picks the mapping branch and forms offset and span, stage 2
// multiplies the offset by the output range, stage 3 splits both operands
// into sign and magnitude for the divider.
// ---------------------------------------------------------------------------
module dbs_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire signed [15:0]   sample,
	input  wire dbs_pkg::cfg_t  cfg,
	output logic                out_valid,
	input  wire                 out_ready,
	output dbs_pkg::div_t       out_div,
	output dbs_pkg::side_t      out_side
);

	logic signed [17:0] u18;
	logic signed [17:0] mid18;
	logic signed [17:0] db18;
	logic signed [17:0] hi_edge;
	logic signed [17:0] lo_edge;
	logic signed [17:0] xa;
	logic signed [17:0] span;
	logic signed [16:0] mult;
	logic               zero;
	dbs_pkg::side_t     side;

	logic               valid_s1, valid_s2, valid_s3;
	logic               ready_s1, ready_s2, ready_s3;
	logic signed [17:0] xa_s1, span_s1, span_s2;
	logic signed [16:0] mult_s1;
	logic signed [34:0] prod_s2;
	logic signed [34:0] prod_neg;
	logic signed [17:0] span_neg;
	dbs_pkg::side_t     side_s1, side_s2, side_s3;
	dbs_pkg::side_t     side_sgn;
	dbs_pkg::div_t      div_s3;

	// Stage handshake: a stage takes new data when empty or draining.
	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Branch selection: offset from the band edge, span and output range.
	always_comb begin
		u18     = 18'(sample);
		mid18   = 18'(cfg.in_middle);
		db18    = {3'b000, cfg.dead_band_width};
		hi_edge = mid18 + db18;
		lo_edge = mid18 - db18;
		xa      = '0;
		span    = '0;
		mult    = '0;
		zero    = 1'b1;
		side    = '0;
		case (cfg.mode)
			dbs_pkg::MODE_NORMAL: begin
				zero    = 1'b0;
				xa      = u18 - 18'(cfg.in_low);
				span    = 18'(cfg.in_high) - 18'(cfg.in_low);
				mult    = {2'b00, cfg.out_high};
				side.hi = {1'b0, cfg.out_high};
			end
			dbs_pkg::MODE_MID_REST: begin
				if (u18 > lo_edge && u18 < hi_edge) begin
					side.band = 1'b1;
				end else if (u18 > mid18) begin
					zero    = 1'b0;
					xa      = u18 - hi_edge;
					span    = 18'(cfg.in_high) - hi_edge;
					mult    = {2'b00, cfg.out_high};
					side.hi = {1'b0, cfg.out_high};
				end else begin
					zero    = 1'b0;
					xa      = u18 - lo_edge;
					span    = 18'(cfg.in_low) - lo_edge;
					mult    = 17'(cfg.out_low);
					side.lo = cfg.out_low;
				end
			end
			default: begin
			end
		endcase
		side.fault = !zero && (span == '0);
		side.zero  = zero || side.fault;
	end

	// Stage 1 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			xa_s1   <= xa;
			span_s1 <= span;
			mult_s1 <= mult;
			side_s1 <= side;
		end
	end

	// Stage 2: offset times output range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			prod_s2 <= xa_s1 * mult_s1;
			span_s2 <= span_s1;
			side_s2 <= side_s1;
		end
	end

	// Stage 3: sign and magnitude of numerator and span.
	assign prod_neg = -prod_s2;
	assign span_neg = -span_s2;

	// The quotient sign joins the side information.
	always_comb begin
		side_sgn     = side_s2;
		side_sgn.neg = prod_s2[34] ^ span_s2[17];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			div_s3.rem   <= '0;
			div_s3.dd    <= prod_s2[34] ? prod_neg[31:0] : prod_s2[31:0];
			div_s3.dvs   <= span_s2[17] ? span_neg[16:0] : span_s2[16:0];
			side_s3      <= side_sgn;
		end
	end

	assign out_valid = valid_s3;
	assign out_div   = div_s3;
	assign out_side  = side_s3;

endmodule
`default_nettype wire

@@ src/dbs_div_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dbs_div_stage: one slice of the unsigned divider
// Resolves four quotient bits per transaction with restoring steps and
// registers the result together with its side information.
// ---------------------------------------------------------------------------
module dbs_div_stage (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire dbs_pkg::div_t   in_div,
	input  wire dbs_pkg::side_t  in_side,
	output logic                 out_valid,
	input  wire                  out_ready,
	output dbs_pkg::div_t        out_div,
	output dbs_pkg::side_t       out_side
);

	dbs_pkg::div_t  stepped;
	logic           valid_s1;
	dbs_pkg::div_t  div_s1;
	dbs_pkg::side_t side_s1;

	assign in_ready = !valid_s1 || out_ready;

	// Four chained restoring steps on a 17-bit remainder.
	always_comb begin
		stepped = in_div;
		for (int i = 0; i < dbs_pkg::DIV_PER_STAGE; i++) begin
			stepped = dbs_pkg::div_step(stepped);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			div_s1  <= stepped;
			side_s1 <= in_side;
		end
	end

	assign out_valid = valid_s1;
	assign out_div   = div_s1;
	assign out_side  = side_s1;

endmodule
`default_nettype wire

@@ src/dbs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dbs_back: sign restore, clamp and output register
// Applies the quotient sign, clamps to the branch limits, forces zero for
// ignored modes, the dead band and a zero span, and holds the result.
// ---------------------------------------------------------------------------
module dbs_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire dbs_pkg::div_t  in_div,
	input  wire dbs_pkg::side_t in_side,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic signed [15:0]  command,
	output logic                in_dead_band,
	output logic                divide_fault
);

	logic signed [32:0] mag;
	logic signed [32:0] val;
	logic signed [32:0] lo33;
	logic signed [32:0] hi33;
	logic signed [15:0] clamped;

	logic               valid_s1;
	logic signed [15:0] cmd_s1;
	logic               band_s1;
	logic               fault_s1;

	assign in_ready = !valid_s1 || out_ready;

	// Truncating quotient sign, then clamp with the low limit checked first.
	always_comb begin
		mag  = $signed({1'b0, in_div.dd});
		val  = in_side.neg ? -mag : mag;
		lo33 = 33'(in_side.lo);
		hi33 = 33'(in_side.hi);
		if (in_side.zero) begin
			clamped = '0;
		end else if (val < lo33) begin
			clamped = in_side.lo;
		end else if (val > hi33) begin
			clamped = in_side.hi;
		end else begin
			clamped = val[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1   <= clamped;
			band_s1  <= in_side.band;
			fault_s1 <= in_side.fault;
		end
	end

	assign out_valid    = valid_s1;
	assign command      = cmd_s1;
	assign in_dead_band = band_s1;
	assign divide_fault = fault_s1;

endmodule
`default_nettype wire

@@ src/deadband_scaler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// deadband_scaler: dead band, linear map and clamp of a raw sample
// Turns one signed sample into a scaled, clamped command under the mode
// and limits held in the configuration registers.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | sample
//  output   | out_valid / out_ready| command, in_dead_band, divide_fault
//  config   | cfg_we               | cfg_index, cfg_data
//
//  One transaction per clock unless the output stalls; the stages are branch select,
//  multiply, sign split, eight divider slices of four quotient bits each, and clamp.
//  The divider depth sets the latency of the whole pipeline.
//  Reset clears all valid bits and loads the default register values.
//  A stalled output holds; each stage refills as soon as it empties, so
//  bubbles collapse and nothing is dropped or repeated.
// ---------------------------------------------------------------------------
module deadband_scaler (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire signed [15:0]  sample,
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [15:0] command,
	output logic               in_dead_band,
	output logic               divide_fault,
	input  wire                cfg_we,
	input  wire [2:0]          cfg_index,
	input  wire [15:0]         cfg_data
);

	localparam int NS = dbs_pkg::DIV_STAGES;

	dbs_pkg::cfg_t  cfg_q;
	logic [NS:0]    chain_valid;
	logic [NS:0]    chain_ready;
	dbs_pkg::div_t  chain_div  [NS+1];
	dbs_pkg::side_t chain_side [NS+1];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode            <= dbs_pkg::MODE_IGNORED;
			cfg_q.dead_band_width <= 15'd0;
			cfg_q.in_low          <= 16'sd0;
			cfg_q.in_middle       <= 16'sd2048;
			cfg_q.in_high         <= 16'sd4095;
			cfg_q.out_low         <= -16'sd1000;
			cfg_q.out_high        <= 15'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				dbs_pkg::REG_INPUT_MODE:      cfg_q.mode <= dbs_pkg::mode_t'(cfg_data[1:0]);
				dbs_pkg::REG_DEAD_BAND_WIDTH: cfg_q.dead_band_width <= cfg_data[14:0];
				dbs_pkg::REG_IN_LOW:          cfg_q.in_low <= cfg_data;
				dbs_pkg::REG_IN_MIDDLE:       cfg_q.in_middle <= cfg_data;
				dbs_pkg::REG_IN_HIGH:         cfg_q.in_high <= cfg_data;
				dbs_pkg::REG_OUT_LOW:         cfg_q.out_low <= cfg_data;
				dbs_pkg::REG_OUT_HIGH:        cfg_q.out_high <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	// Branch select, multiply and sign split.
	dbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.cfg       (cfg_q),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_div   (chain_div[0]),
		.out_side  (chain_side[0])
	);

	// Divider slices.
	for (genvar g = 0; g < NS; g++) begin : g_div
		dbs_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[g]),
			.in_ready  (chain_ready[g]),
			.in_div    (chain_div[g]),
			.in_side   (chain_side[g]),
			.out_valid (chain_valid[g+1]),
			.out_ready (chain_ready[g+1]),
			.out_div   (chain_div[g+1]),
			.out_side  (chain_side[g+1])
		);
	end

	// Sign restore, clamp and output register.
	dbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (chain_valid[NS]),
		.in_ready     (chain_ready[NS]),
		.in_div       (chain_div[NS]),
		.in_side      (chain_side[NS]),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.command      (command),
		.in_dead_band (in_dead_band),
		.divide_fault (divide_fault)
	);

endmodule
`default_nettype wire

@@ src/dbs_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dbs_checker: port-level assertions for the dead band scaler
// Watches both channels for stall behavior and the output for consistency
// of the command with its flags.
// ---------------------------------------------------------------------------
module dbs_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               in_ready,
	input  wire signed [15:0] sample,
	input  wire               out_valid,
	input  wire               out_ready,
	input  wire signed [15:0] command,
	input  wire               in_dead_band,
	input  wire               divide_fault
);

	// A waiting input transaction keeps its valid and its sample.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(sample))
		else $error("waiting input transaction changed");

	// A stalled result transaction keeps its valid and its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command)
			&& $stable(in_dead_band) && $stable(divide_fault))
		else $error("stalled output transaction changed");

	// A sample inside the dead band gives a zero command and no fault.
	a_band_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_dead_band |-> command == 16'sd0 && !divide_fault)
		else $error("dead band result not zero or faulted");

	// A zero span forces the command to zero.
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_fault |-> command == 16'sd0)
		else $error("divide fault with nonzero command");

endmodule

bind deadband_scaler dbs_checker u_dbs_checker (.*);
`default_nettype wire
